// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master transaction engine.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int CFG_W          = 16;
  localparam int DELAY_BITS_DEF = 16;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [CFG_W-1:0] BIT_TICKS_RST = 16'd250;
  localparam logic [CFG_W-1:0] ACK_TICKS_RST = 16'd1250;

  // register select bit of paddr (byte address 4*i)
  localparam logic REG_BIT_TICKS = 1'b0;
  localparam logic REG_ACK_TICKS = 1'b1;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_S1     = 4'd1;
  localparam logic [3:0] PH_S2     = 4'd2;
  localparam logic [3:0] PH_TB_LO  = 4'd3;
  localparam logic [3:0] PH_TB_HI  = 4'd4;
  localparam logic [3:0] PH_ACK_LO = 4'd5;
  localparam logic [3:0] PH_ACK_HI = 4'd6;
  localparam logic [3:0] PH_WAIT   = 4'd7;
  localparam logic [3:0] PH_RB_LO  = 4'd8;
  localparam logic [3:0] PH_RB_HI  = 4'd9;
  localparam logic [3:0] PH_MA_LO  = 4'd10;
  localparam logic [3:0] PH_MA_HI  = 4'd11;
  localparam logic [3:0] PH_P1     = 4'd12;
  localparam logic [3:0] PH_P2     = 4'd13;

  typedef struct packed {
    logic [CFG_W-1:0] bit_ticks;
    logic [CFG_W-1:0] ack_ticks;
  } i2cm_cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       write_byte_valid;
    logic       sda_sample;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_enable;
    logic       sda_level;
    logic       busy_res;
    logic       write_byte_request;
    logic [7:0] read_byte;
    logic       read_byte_valid;
    logic       done_res;
    logic       success;
  } i2cm_out_t;

  // engine state apart from the delay counter, whose width is a parameter
  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] shift_byte;
    logic [3:0] bit_index;
    logic [7:0] bytes_left;
    logic       is_read;
    logic       pin_scl;
    logic       pin_en;
    logic       pin_lvl;
    logic       addr_stage;
    logic       all_ok;
  } i2cm_state_t;

endpackage

// ===== src/i2c_master_transaction_engine.sv =====
// Top level of the tick-driven I2C master: input register, sequencer state, result register.
`timescale 1ns / 1ps
// Each input transaction is one timing tick of a 7-bit-address I2C master; every tick
// returns exactly one result with the pin levels for that tick and the status strobes.
// One tick is taken per clock, sustained, whenever the result side does not stall; a
// tick goes from the input register through the combinational next-state step into
// the result register. The input side stalls only while both the input register and
// an untaken result are held. Phase lengths come from the bit_phase_ticks (byte
// address 0) and ack_phase_ticks (byte address 4) registers, clamped to the DELAY_BITS
// counter; write them only while idle.
module i2c_master_transaction_engine #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0] paddr,
  input  logic [i2cm_pkg::PDATA_W-1:0] pwdata,
  output logic [i2cm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [6:0]                   in_dev_addr,
  input  logic [7:0]                   in_byte_count,
  input  logic [7:0]                   in_write_byte,
  input  logic                         in_write_byte_valid,
  input  logic                         in_sda_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_scl_level,
  output logic                         out_sda_drive_enable,
  output logic                         out_sda_level,
  output logic                         out_busy_res,
  output logic                         out_write_byte_request,
  output logic [7:0]                   out_read_byte,
  output logic                         out_read_byte_valid,
  output logic                         out_done_res,
  output logic                         out_success
);

  i2cm_pkg::i2cm_cfg_t   cfg;
  i2cm_pkg::i2cm_in_t    item_r, item_nxt;
  logic                  in_vld_r, in_vld_nxt;
  i2cm_pkg::i2cm_state_t st_r, st_nxt;
  logic [DELAY_BITS-1:0] dly_r, dly_nxt;
  i2cm_pkg::i2cm_out_t   res_r, res_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_adv;
  logic                  fire;
  logic                  in_take;

  i2cm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cm_pkg::i2cm_state_t st_step;
  logic [DELAY_BITS-1:0] dly_step;
  i2cm_pkg::i2cm_out_t   res_step;

  i2cm_step #(.DELAY_BITS(DELAY_BITS)) u_step (
    .cfg_i  (cfg),
    .item_i (item_r),
    .st_i   (st_r),
    .dly_i  (dly_r),
    .st_o   (st_step),
    .dly_o  (dly_step),
    .res_o  (res_step)
  );

  assign out_adv  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_adv;
  assign in_stall = in_vld_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_nxt   = item_r;
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      item_nxt.req_type         = in_req_type;
      item_nxt.dev_addr         = in_dev_addr;
      item_nxt.byte_count       = in_byte_count;
      item_nxt.write_byte       = in_write_byte;
      item_nxt.write_byte_valid = in_write_byte_valid;
      item_nxt.sda_sample       = in_sda_sample;
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    dly_nxt     = dly_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (fire) begin
      st_nxt      = st_step;
      dly_nxt     = dly_step;
      res_nxt     = res_step;
      out_vld_nxt = 1'b1;
    end else if (out_adv) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      dly_r         <= '0;
      st_r          <= '0;
      st_r.phase    <= i2cm_pkg::PH_IDLE;
      st_r.pin_scl  <= 1'b1;
      st_r.all_ok   <= 1'b1;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      dly_r     <= dly_nxt;
      st_r      <= st_nxt;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_scl_level          = res_r.scl_level;
  assign out_sda_drive_enable   = res_r.sda_drive_enable;
  assign out_sda_level          = res_r.sda_level;
  assign out_busy_res           = res_r.busy_res;
  assign out_write_byte_request = res_r.write_byte_request;
  assign out_read_byte          = res_r.read_byte;
  assign out_read_byte_valid    = res_r.read_byte_valid;
  assign out_done_res           = res_r.done_res;
  assign out_success            = res_r.success;

endmodule

// ===== src/i2cm_regs.sv =====
// APB-style configuration registers for the phase tick counts.
`timescale 1ns / 1ps
module i2cm_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::PADDR_W-1:0]        paddr,
  input  logic [i2cm_pkg::PDATA_W-1:0]        pwdata,
  output logic [i2cm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output i2cm_pkg::i2cm_cfg_t                 cfg_o
);

  logic [i2cm_pkg::CFG_W-1:0] bit_ticks_r, bit_ticks_nxt;
  logic [i2cm_pkg::CFG_W-1:0] ack_ticks_r, ack_ticks_nxt;
  logic                       wr_en;
  logic                       sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[2];

  always_comb begin
    bit_ticks_nxt = bit_ticks_r;
    ack_ticks_nxt = ack_ticks_r;
    if (wr_en) begin
      unique case (sel)
        i2cm_pkg::REG_BIT_TICKS: bit_ticks_nxt = pwdata[i2cm_pkg::CFG_W-1:0];
        i2cm_pkg::REG_ACK_TICKS: ack_ticks_nxt = pwdata[i2cm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r <= i2cm_pkg::BIT_TICKS_RST;
      ack_ticks_r <= i2cm_pkg::ACK_TICKS_RST;
    end else begin
      bit_ticks_r <= bit_ticks_nxt;
      ack_ticks_r <= ack_ticks_nxt;
    end
  end

  always_comb begin
    unique case (sel)
      i2cm_pkg::REG_BIT_TICKS: prdata = i2cm_pkg::PDATA_W'(bit_ticks_r);
      i2cm_pkg::REG_ACK_TICKS: prdata = i2cm_pkg::PDATA_W'(ack_ticks_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.bit_ticks = bit_ticks_r;
  assign cfg_o.ack_ticks = ack_ticks_r;

endmodule

// ===== src/i2cm_step.sv =====
// Next-state and result logic for one tick of the bus sequencer.
`timescale 1ns / 1ps
module i2cm_step #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
  input  i2cm_pkg::i2cm_cfg_t   cfg_i,
  input  i2cm_pkg::i2cm_in_t    item_i,
  input  i2cm_pkg::i2cm_state_t st_i,
  input  logic [DELAY_BITS-1:0] dly_i,
  output i2cm_pkg::i2cm_state_t st_o,
  output logic [DELAY_BITS-1:0] dly_o,
  output i2cm_pkg::i2cm_out_t   res_o
);

  localparam int CW = (DELAY_BITS > i2cm_pkg::CFG_W) ? DELAY_BITS : i2cm_pkg::CFG_W;
  localparam logic [CW-1:0] LIM = CW'({DELAY_BITS{1'b1}});

  // clamp a tick count into the counter range, zero counts as one
  function automatic logic [DELAY_BITS-1:0] eff_ticks(input logic [i2cm_pkg::CFG_W-1:0] v);
    logic [CW-1:0] w;
    begin
      w = CW'(v);
      if (w > LIM) w = LIM;
      if (w == '0) w = CW'(1);
      return DELAY_BITS'(w);
    end
  endfunction

  logic [DELAY_BITS-1:0] bt;
  logic [DELAY_BITS-1:0] at;

  assign bt = eff_ticks(cfg_i.bit_ticks);
  assign at = eff_ticks(cfg_i.ack_ticks);

  always_comb begin
    i2cm_pkg::i2cm_state_t s;
    logic [DELAY_BITS-1:0] dc;
    i2cm_pkg::i2cm_out_t   o;
    s = st_i;
    dc = dly_i;
    o = '0;

    // start request from idle
    if (s.phase == i2cm_pkg::PH_IDLE &&
        (item_i.req_type == i2cm_pkg::REQ_WRITE || item_i.req_type == i2cm_pkg::REQ_READ)) begin
      if (item_i.byte_count == 8'd0) begin
        o.done_res = 1'b1;
      end else begin
        s.is_read    = (item_i.req_type == i2cm_pkg::REQ_READ);
        s.shift_byte = {item_i.dev_addr, s.is_read};
        s.bit_index  = 4'd0;
        s.bytes_left = item_i.byte_count;
        s.addr_stage = 1'b1;
        s.all_ok     = 1'b1;
        s.phase      = i2cm_pkg::PH_S1;
        s.pin_scl    = 1'b1;
        s.pin_en     = 1'b1;
        s.pin_lvl    = 1'b1;
        dc           = bt;
      end
    end

    // hold SCL low until the next write byte shows up
    if (s.phase == i2cm_pkg::PH_WAIT) begin
      if (item_i.write_byte_valid) begin
        s.shift_byte = item_i.write_byte;
        s.bit_index  = 4'd0;
        s.phase      = i2cm_pkg::PH_TB_LO;
        s.pin_scl    = 1'b0;
        s.pin_en     = 1'b1;
        s.pin_lvl    = item_i.write_byte[7];
        dc           = bt;
      end else begin
        o.write_byte_request = 1'b1;
      end
    end

    o.scl_level        = s.pin_scl;
    o.sda_drive_enable = s.pin_en;
    o.sda_level        = s.pin_lvl;

    if (s.phase != i2cm_pkg::PH_IDLE && s.phase != i2cm_pkg::PH_WAIT) begin
      if (dc != '0) dc = dc - 1'b1;
      if (dc == '0) begin
        unique case (s.phase)
          i2cm_pkg::PH_S1: begin
            s.phase = i2cm_pkg::PH_S2;
            s.pin_scl = 1'b1; s.pin_en = 1'b1; s.pin_lvl = 1'b0; dc = bt;
          end
          i2cm_pkg::PH_S2: begin
            s.phase = i2cm_pkg::PH_TB_LO;
            s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = s.shift_byte[7]; dc = bt;
          end
          i2cm_pkg::PH_TB_LO: begin
            s.phase = i2cm_pkg::PH_TB_HI;
            s.pin_scl = 1'b1; dc = bt;
          end
          i2cm_pkg::PH_TB_HI: begin
            s.shift_byte = {s.shift_byte[6:0], 1'b0};
            s.bit_index  = s.bit_index + 4'd1;
            if (s.bit_index < 4'd8) begin
              s.phase = i2cm_pkg::PH_TB_LO;
              s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = s.shift_byte[7];
            end else begin
              s.phase = i2cm_pkg::PH_ACK_LO;
              s.pin_scl = 1'b0; s.pin_en = 1'b0; s.pin_lvl = 1'b0;
            end
            dc = bt;
          end
          i2cm_pkg::PH_ACK_LO: begin
            s.phase = i2cm_pkg::PH_ACK_HI;
            s.pin_scl = 1'b1; s.pin_en = 1'b0; s.pin_lvl = 1'b0; dc = at;
          end
          i2cm_pkg::PH_ACK_HI: begin
            if (item_i.sda_sample) begin
              // NACK from the target: drop to STOP and flag the failure
              s.all_ok = 1'b0;
              s.phase = i2cm_pkg::PH_P1;
              s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = 1'b0; dc = bt;
            end else if (s.addr_stage) begin
              s.addr_stage = 1'b0;
              s.bit_index  = 4'd0;
              s.shift_byte = 8'd0;
              s.pin_scl = 1'b0; s.pin_en = 1'b0; s.pin_lvl = 1'b0;
              if (s.is_read) begin
                s.phase = i2cm_pkg::PH_RB_LO; dc = bt;
              end else begin
                s.phase = i2cm_pkg::PH_WAIT; dc = '0;
              end
            end else begin
              s.bytes_left = s.bytes_left - 8'd1;
              if (s.bytes_left == 8'd0) begin
                s.phase = i2cm_pkg::PH_P1;
                s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = 1'b0; dc = bt;
              end else begin
                s.phase = i2cm_pkg::PH_WAIT;
                s.pin_scl = 1'b0; s.pin_en = 1'b0; s.pin_lvl = 1'b0; dc = '0;
              end
            end
          end
          i2cm_pkg::PH_RB_LO: begin
            s.phase = i2cm_pkg::PH_RB_HI;
            s.pin_scl = 1'b1; s.pin_en = 1'b0; s.pin_lvl = 1'b0; dc = bt;
          end
          i2cm_pkg::PH_RB_HI: begin
            s.shift_byte = {s.shift_byte[6:0], item_i.sda_sample};
            s.bit_index  = s.bit_index + 4'd1;
            if (s.bit_index < 4'd8) begin
              s.phase = i2cm_pkg::PH_RB_LO;
              s.pin_scl = 1'b0; s.pin_en = 1'b0; s.pin_lvl = 1'b0;
            end else begin
              o.read_byte       = s.shift_byte;
              o.read_byte_valid = 1'b1;
              s.bytes_left = s.bytes_left - 8'd1;
              // ACK all but the last byte, NACK the last
              s.phase = i2cm_pkg::PH_MA_LO;
              s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = (s.bytes_left == 8'd0);
            end
            dc = bt;
          end
          i2cm_pkg::PH_MA_LO: begin
            s.phase = i2cm_pkg::PH_MA_HI;
            s.pin_scl = 1'b1; dc = at;
          end
          i2cm_pkg::PH_MA_HI: begin
            if (s.bytes_left != 8'd0) begin
              s.bit_index  = 4'd0;
              s.shift_byte = 8'd0;
              s.phase = i2cm_pkg::PH_RB_LO;
              s.pin_scl = 1'b0; s.pin_en = 1'b0; s.pin_lvl = 1'b0;
            end else begin
              s.phase = i2cm_pkg::PH_P1;
              s.pin_scl = 1'b0; s.pin_en = 1'b1; s.pin_lvl = 1'b0;
            end
            dc = bt;
          end
          i2cm_pkg::PH_P1: begin
            s.phase = i2cm_pkg::PH_P2;
            s.pin_scl = 1'b1; s.pin_en = 1'b1; s.pin_lvl = 1'b0; dc = bt;
          end
          i2cm_pkg::PH_P2: begin
            s.phase = i2cm_pkg::PH_IDLE;
            s.pin_scl = 1'b1; s.pin_en = 1'b1; s.pin_lvl = 1'b1; dc = '0;
            o.done_res = 1'b1;
            o.success  = s.all_ok;
          end
          default: begin
            s.phase = i2cm_pkg::PH_IDLE;
            s.pin_scl = 1'b1; s.pin_en = 1'b0; s.pin_lvl = 1'b0; dc = '0;
          end
        endcase
      end
    end

    o.busy_res = (s.phase != i2cm_pkg::PH_IDLE);

    st_o  = s;
    dly_o = dc;
    res_o = o;
  end

endmodule

// ===== src/i2cm_checker.sv =====
// Port-level checks for the I2C master transaction engine, bound to the top level.
`timescale 1ns / 1ps
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_scl_level,
  input logic       out_busy_res,
  input logic       out_write_byte_request,
  input logic [7:0] out_read_byte,
  input logic       out_read_byte_valid,
  input logic       out_done_res,
  input logic       out_success
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_done_res) &&
      $stable(out_read_byte) && $stable(out_scl_level))
    else $error("stalled result changed");

  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_done_res)
    else $error("success without done");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_byte_valid |-> out_read_byte == 8'd0 && !out_done_res ||
      out_valid && !out_read_byte_valid && out_read_byte == 8'd0)
    else $error("read byte nonzero without strobe");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_byte_request |-> out_busy_res && !out_read_byte_valid &&
      !out_done_res)
    else $error("write byte request outside an active write");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_i2cm_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the tick-driven I2C master transaction engine.
`timescale 1ns / 1ps
module tb_top;
  import i2cm_pkg::*;

  localparam logic [1:0] REQ_RSVD = 2'd3;
  localparam int LIMIT  = 600000;
  localparam int N_ROWS = 7;
  localparam int N_STEPS = 6;

  typedef struct packed {
    i2cm_in_t   stim;
    logic [7:0] reps;
    logic       typed;
    i2cm_out_t  want;
  } drow_t;

  localparam i2cm_out_t IDLE_PINS = '{scl_level: 1'b1, default: '0};
  localparam i2cm_out_t ZERO_FAIL = '{scl_level: 1'b1, done_res: 1'b1, default: '0};

  // walk: reset idle, zero-count requests at the field extremes, reserved code,
  // then a write to the top address that the target never acknowledges
  localparam drow_t PLAN [N_ROWS] = '{
    '{stim: '{REQ_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b0}, reps: 8'd1,  typed: 1'b1,
      want: IDLE_PINS},
    '{stim: '{REQ_WRITE, 7'h7F, 8'h00, 8'hFF, 1'b1, 1'b1}, reps: 8'd1,  typed: 1'b1,
      want: ZERO_FAIL},
    '{stim: '{REQ_READ,  7'h00, 8'h00, 8'h00, 1'b0, 1'b0}, reps: 8'd1,  typed: 1'b1,
      want: ZERO_FAIL},
    '{stim: '{REQ_RSVD,  7'h55, 8'hFF, 8'hAA, 1'b1, 1'b0}, reps: 8'd1,  typed: 1'b1,
      want: IDLE_PINS},
    '{stim: '{REQ_WRITE, 7'h7F, 8'hFF, 8'h00, 1'b0, 1'b1}, reps: 8'd1,  typed: 1'b0,
      want: '0},
    '{stim: '{REQ_READ,  7'h00, 8'h01, 8'hFF, 1'b1, 1'b1}, reps: 8'd1,  typed: 1'b0,
      want: '0},
    '{stim: '{REQ_TICK,  7'h00, 8'h00, 8'h5A, 1'b1, 1'b1}, reps: 8'd21, typed: 1'b0,
      want: '0}
  };

  localparam logic [15:0] BIT_STEPS [N_STEPS] = '{16'd1, 16'd2, 16'd1, 16'd0, 16'd3, 16'd4};
  localparam logic [15:0] ACK_STEPS [N_STEPS] = '{16'd1, 16'd1, 16'd3, 16'd0, 16'd2, 16'd6};

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [6:0]  in_dev_addr;
  logic [7:0]  in_byte_count;
  logic [7:0]  in_write_byte;
  logic        in_write_byte_valid;
  logic        in_sda_sample;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl_level;
  logic        out_sda_drive_enable;
  logic        out_sda_level;
  logic        out_busy_res;
  logic        out_write_byte_request;
  logic [7:0]  out_read_byte;
  logic        out_read_byte_valid;
  logic        out_done_res;
  logic        out_success;

  i2c_master_transaction_engine u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_dev_addr            (in_dev_addr),
    .in_byte_count          (in_byte_count),
    .in_write_byte          (in_write_byte),
    .in_write_byte_valid    (in_write_byte_valid),
    .in_sda_sample          (in_sda_sample),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_scl_level          (out_scl_level),
    .out_sda_drive_enable   (out_sda_drive_enable),
    .out_sda_level          (out_sda_level),
    .out_busy_res           (out_busy_res),
    .out_write_byte_request (out_write_byte_request),
    .out_read_byte          (out_read_byte),
    .out_read_byte_valid    (out_read_byte_valid),
    .out_done_res           (out_done_res),
    .out_success            (out_success)
  );

  // bus engine mirror
  logic [15:0] bit_ticks_cfg = BIT_TICKS_RST;
  logic [15:0] ack_ticks_cfg = ACK_TICKS_RST;
  logic [3:0]  cur_ph    = PH_IDLE;
  logic [15:0] tick_left = '0;
  logic [7:0]  shreg     = '0;
  logic [3:0]  bit_cnt   = '0;
  logic [7:0]  bytes_rem = '0;
  logic        reading   = 1'b0;
  logic        scl_q     = 1'b1;
  logic        en_q      = 1'b0;
  logic        lvl_q     = 1'b0;
  logic        in_addr   = 1'b0;
  logic        acked     = 1'b1;

  i2cm_out_t bus_q [$];
  int        mismatches  = 0;
  int        result_idx  = 0;
  int        phase_ticks = 0;
  int        cycle_cnt   = 0;
  bit        quiet       = 1'b0;
  bit        hold_off_req = 1'b0;
  bit        took_result = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", result_idx, name, got, want));
  endtask

  function automatic void set_phase(input logic [3:0] p, input logic s, input logic e,
                                    input logic l, input logic [15:0] n);
    cur_ph    = p;
    scl_q     = s;
    en_q      = e;
    lvl_q     = e ? l : 1'b0;
    tick_left = n;
  endfunction

  // one timing tick of the engine: pins in effect this tick, status after it
  function automatic i2cm_out_t bus_predict(input i2cm_in_t t);
    i2cm_out_t   r;
    logic [15:0] bt;
    logic [15:0] at;
    r  = '0;
    bt = (bit_ticks_cfg == 16'd0) ? 16'd1 : bit_ticks_cfg;
    at = (ack_ticks_cfg == 16'd0) ? 16'd1 : ack_ticks_cfg;
    if (cur_ph == PH_IDLE && (t.req_type == REQ_WRITE || t.req_type == REQ_READ)) begin
      if (t.byte_count == 8'd0) begin
        r.done_res = 1'b1;
      end else begin
        reading   = (t.req_type == REQ_READ);
        shreg     = {t.dev_addr, reading};
        bit_cnt   = '0;
        bytes_rem = t.byte_count;
        in_addr   = 1'b1;
        acked     = 1'b1;
        set_phase(PH_S1, 1'b1, 1'b1, 1'b1, bt);
      end
    end
    if (cur_ph == PH_WAIT) begin
      if (t.write_byte_valid) begin
        shreg   = t.write_byte;
        bit_cnt = '0;
        set_phase(PH_TB_LO, 1'b0, 1'b1, shreg[7], bt);
      end else begin
        r.write_byte_request = 1'b1;
      end
    end
    r.scl_level        = scl_q;
    r.sda_drive_enable = en_q;
    r.sda_level        = lvl_q;
    if (cur_ph != PH_IDLE && cur_ph != PH_WAIT) begin
      if (tick_left != 16'd0) tick_left = tick_left - 16'd1;
      if (tick_left == 16'd0) begin
        case (cur_ph)
          PH_S1:     set_phase(PH_S2, 1'b1, 1'b1, 1'b0, bt);
          PH_S2:     set_phase(PH_TB_LO, 1'b0, 1'b1, shreg[7], bt);
          PH_TB_LO:  set_phase(PH_TB_HI, 1'b1, en_q, lvl_q, bt);
          PH_TB_HI: begin
            shreg   = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) set_phase(PH_TB_LO, 1'b0, 1'b1, shreg[7], bt);
            else set_phase(PH_ACK_LO, 1'b0, 1'b0, 1'b0, bt);
          end
          PH_ACK_LO: set_phase(PH_ACK_HI, 1'b1, 1'b0, 1'b0, at);
          PH_ACK_HI: begin
            if (t.sda_sample) begin
              acked = 1'b0;
              set_phase(PH_P1, 1'b0, 1'b1, 1'b0, bt);
            end else if (in_addr) begin
              in_addr = 1'b0;
              bit_cnt = '0;
              shreg   = '0;
              if (reading) set_phase(PH_RB_LO, 1'b0, 1'b0, 1'b0, bt);
              else set_phase(PH_WAIT, 1'b0, 1'b0, 1'b0, 16'd0);
            end else begin
              bytes_rem = bytes_rem - 8'd1;
              if (bytes_rem == 8'd0) set_phase(PH_P1, 1'b0, 1'b1, 1'b0, bt);
              else set_phase(PH_WAIT, 1'b0, 1'b0, 1'b0, 16'd0);
            end
          end
          PH_RB_LO:  set_phase(PH_RB_HI, 1'b1, 1'b0, 1'b0, bt);
          PH_RB_HI: begin
            shreg   = {shreg[6:0], t.sda_sample};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
              set_phase(PH_RB_LO, 1'b0, 1'b0, 1'b0, bt);
            end else begin
              r.read_byte       = shreg;
              r.read_byte_valid = 1'b1;
              bytes_rem         = bytes_rem - 8'd1;
              // NACK the last byte, ACK the others
              set_phase(PH_MA_LO, 1'b0, 1'b1, bytes_rem == 8'd0, bt);
            end
          end
          PH_MA_LO:  set_phase(PH_MA_HI, 1'b1, en_q, lvl_q, at);
          PH_MA_HI: begin
            if (bytes_rem != 8'd0) begin
              bit_cnt = '0;
              shreg   = '0;
              set_phase(PH_RB_LO, 1'b0, 1'b0, 1'b0, bt);
            end else begin
              set_phase(PH_P1, 1'b0, 1'b1, 1'b0, bt);
            end
          end
          PH_P1:     set_phase(PH_P2, 1'b1, 1'b1, 1'b0, bt);
          PH_P2: begin
            set_phase(PH_IDLE, 1'b1, 1'b1, 1'b1, 16'd0);
            r.done_res = 1'b1;
            r.success  = acked;
          end
          default:   set_phase(PH_IDLE, 1'b1, 1'b0, 1'b0, 16'd0);
        endcase
      end
    end
    r.busy_res = (cur_ph != PH_IDLE);
    return r;
  endfunction

  function automatic i2cm_in_t rand_tick();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(i2cm_in_t)-1:0];
  endfunction

  // offer one tick, hold the transaction until the engine takes it
  task automatic push_tick(input i2cm_in_t t, input logic typed, input i2cm_out_t want);
    int        gap;
    i2cm_out_t pred;
    gap = quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_req_type         <= t.req_type;
    in_dev_addr         <= t.dev_addr;
    in_byte_count       <= t.byte_count;
    in_write_byte       <= t.write_byte;
    in_write_byte_valid <= t.write_byte_valid;
    in_sda_sample       <= t.sda_sample;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    pred = bus_predict(t);
    bus_q.push_back(typed ? want : pred);
    phase_ticks++;
  endtask

  task automatic run_idle(input int n);
    i2cm_in_t t;
    repeat (n) begin
      t = rand_tick();
      t.byte_count = 8'd0;
      push_tick(t, 1'b0, '0);
    end
  endtask

  // one well-formed bus transfer; fail_at picks the acknowledge the target drops
  task automatic run_transfer(input logic rd_op, input logic [6:0] addr, input logic [7:0] cnt,
                              input int fail_at, input logic hush);
    i2cm_in_t   t;
    int         acks;
    logic [3:0] was;
    quiet = hush || ($urandom_range(0, 3) == 0);
    acks  = 0;
    t = rand_tick();
    t.req_type   = rd_op ? REQ_READ : REQ_WRITE;
    t.dev_addr   = addr;
    t.byte_count = cnt;
    push_tick(t, 1'b0, '0);
    while (cur_ph != PH_IDLE) begin
      t = rand_tick();
      if (cur_ph == PH_ACK_HI) t.sda_sample = (acks == fail_at);
      if (cur_ph == PH_WAIT) t.write_byte_valid = ($urandom_range(0, 2) != 0);
      was = cur_ph;
      push_tick(t, 1'b0, '0);
      if (was == PH_ACK_HI && cur_ph != PH_ACK_HI) acks++;
    end
  endtask

  // drain to idle, then hold off until every result is back
  task automatic settle();
    i2cm_in_t t;
    while (cur_ph != PH_IDLE) begin
      t = rand_tick();
      t.req_type = REQ_TICK;
      push_tick(t, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
    end
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(input logic sel, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(1'b1, sel, {16'd0, val}, rd);
    if (sel == REG_BIT_TICKS) bit_ticks_cfg = val;
    else ack_ticks_cfg = val;
    apb_access(1'b0, sel, '0, rd);
    if (rd !== {16'd0, val}) report_mismatch($sformatf("reg %0d reads %0h", sel, rd));
  endtask

  always @(negedge clk) begin
    i2cm_out_t got;
    i2cm_out_t want;
    took_result = rst_n && out_valid && !out_stall;
    if (took_result) begin
      got = {out_scl_level, out_sda_drive_enable, out_sda_level, out_busy_res,
             out_write_byte_request, out_read_byte, out_read_byte_valid, out_done_res,
             out_success};
      if (bus_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick pending", result_idx));
      end else begin
        want = bus_q.pop_front();
        cmp_field("scl_level", got.scl_level, want.scl_level);
        cmp_field("sda_drive_enable", got.sda_drive_enable, want.sda_drive_enable);
        cmp_field("sda_level", got.sda_level, want.sda_level);
        cmp_field("busy_res", got.busy_res, want.busy_res);
        cmp_field("write_byte_request", got.write_byte_request, want.write_byte_request);
        cmp_field("read_byte", got.read_byte, want.read_byte);
        cmp_field("read_byte_valid", got.read_byte_valid, want.read_byte_valid);
        cmp_field("done_res", got.done_res, want.done_res);
        cmp_field("success", got.success, want.success);
      end
      result_idx++;
    end
  end

  // result side: random stall per transaction, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = 300;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (took_result) break;
      end
    end
  end

  initial begin
    logic [31:0] rd;
    logic [15:0] bsel;
    logic [15:0] asel;
    logic        rd_op;
    logic [7:0]  cnt;
    int          fail_at;
    int          pick;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_valid            = 1'b0;
    in_req_type         = REQ_TICK;
    in_dev_addr         = '0;
    in_byte_count       = '0;
    in_write_byte       = '0;
    in_write_byte_valid = 1'b0;
    in_sda_sample       = 1'b0;
    rst_n               = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, REG_BIT_TICKS, '0, rd);
    if (rd !== {16'd0, BIT_TICKS_RST}) report_mismatch($sformatf("bit ticks reset %0h", rd));
    apb_access(1'b0, REG_ACK_TICKS, '0, rd);
    if (rd !== {16'd0, ACK_TICKS_RST}) report_mismatch($sformatf("ack ticks reset %0h", rd));

    // shortest phases so the directed rows run a whole transfer
    set_reg(REG_BIT_TICKS, 16'd1);
    set_reg(REG_ACK_TICKS, 16'd1);
    quiet = 1'b0;
    for (int i = 0; i < N_ROWS; i++)
      repeat (PLAN[i].reps) push_tick(PLAN[i].stim, PLAN[i].typed, PLAN[i].want);

    for (int k = 0; k < N_STEPS; k++) begin
      settle();
      bsel = BIT_STEPS[k];
      asel = ACK_STEPS[k];
      if (k == 4) begin
        bsel = $urandom_range(1, 4);
        asel = $urandom_range(1, 6);
      end
      set_reg(REG_BIT_TICKS, bsel);
      set_reg(REG_ACK_TICKS, asel);
      if (k == 0) hold_off_req = 1'b1;
      phase_ticks = 0;
      while (phase_ticks < 150) begin
        run_idle($urandom_range(0, 3));
        rd_op = $urandom_range(0, 1);
        pick  = $urandom_range(0, 19);
        if (pick < 14) cnt = $urandom_range(1, 3);
        else if (pick < 17) cnt = $urandom_range(4, 8);
        else cnt = $urandom_range(9, 255);
        // long transfers end early on a dropped acknowledge
        if (cnt > 8) fail_at = rd_op ? 0 : $urandom_range(0, 2);
        else if ($urandom_range(0, 4) == 0) fail_at = rd_op ? 0 : $urandom_range(0, cnt);
        else fail_at = -1;
        run_transfer(rd_op, $urandom, cnt, fail_at, 1'b0);
      end
    end

    settle();
    set_reg(REG_BIT_TICKS, 16'hFFFF);
    set_reg(REG_ACK_TICKS, 16'd1);
    run_idle(20);

    settle();
    set_reg(REG_BIT_TICKS, 16'd2);
    set_reg(REG_ACK_TICKS, 16'hFFFF);
    run_transfer(1'b0, $urandom, 8'd1, 0, 1'b1);

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cm_pkg.sv
src/i2cm_regs.sv
src/i2cm_step.sv
src/i2c_master_transaction_engine.sv
src/i2cm_checker.sv
test/tb_top.sv
